FILE: rtl/core/rlse_pkg.sv
// Shared types and constants for the LWE sample extraction block.
`default_nettype none

package rlse_pkg;

   localparam int RING_MAX  = 4096;
   localparam int COEF_BITS = 60;
   localparam int IDX_BITS  = $clog2(RING_MAX);
   localparam int SIZE_BITS = IDX_BITS + 1;
   localparam int MOD_BITS  = COEF_BITS + 1;
   localparam int VAR_BITS  = 2;
   localparam int DATA_BITS = 64;
   localparam int REG_BITS  = 2;
   localparam int ADDR_BITS = REG_BITS + 3;

   localparam logic [SIZE_BITS-1:0] RING_MAX_SIZE = SIZE_BITS'(RING_MAX);

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef enum logic [REG_BITS-1:0] {
      REG_RING_SIZE    = 2'd0,
      REG_TARGET_SLOT  = 2'd1,
      REG_COEF_MODULUS = 2'd2,
      REG_VARIANT      = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] ring_size;
      logic [IDX_BITS-1:0]  target_slot;
      logic [MOD_BITS-1:0]  coef_modulus;
      logic [VAR_BITS-1:0]  variant;
   } cfg_type;

   typedef struct packed {
      logic                 mode;
      logic [IDX_BITS-1:0]  position;
      logic [COEF_BITS-1:0] elem0_value;
      logic [COEF_BITS-1:0] elem1_value;
   } req_type;

   typedef struct packed {
      logic [COEF_BITS-1:0] mask_value;
      logic [COEF_BITS-1:0] body_value;
      logic                 range_error;
   } rsp_type;

   typedef struct packed {
      logic                 negate;
      logic                 range_error;
      logic [COEF_BITS-1:0] body_value;
   } stage_type;

endpackage

`default_nettype wire

FILE: rtl/core/rlse_csr.sv
// Configuration registers of the LWE sample extraction block behind an APB-style port.
`default_nettype none

module rlse_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [rlse_pkg::ADDR_BITS-1:0]  paddr,
   input  wire logic [rlse_pkg::DATA_BITS-1:0]  pwdata,
   output logic      [rlse_pkg::DATA_BITS-1:0]  prdata,
   output logic                                 pready,
   output rlse_pkg::cfg_type                    cfg
);

   rlse_pkg::cfg_type     cfg_ff;
   rlse_pkg::cfg_type     cfg_in;
   rlse_pkg::csr_reg_type reg_sel;
   logic                  wr_en;

   assign reg_sel = rlse_pkg::csr_reg_type'(paddr[rlse_pkg::ADDR_BITS-1:3]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            rlse_pkg::REG_RING_SIZE: begin
               cfg_in.ring_size = pwdata[rlse_pkg::SIZE_BITS-1:0];
            end
            rlse_pkg::REG_TARGET_SLOT: begin
               cfg_in.target_slot = pwdata[rlse_pkg::IDX_BITS-1:0];
            end
            rlse_pkg::REG_COEF_MODULUS: begin
               cfg_in.coef_modulus = pwdata[rlse_pkg::MOD_BITS-1:0];
            end
            rlse_pkg::REG_VARIANT: begin
               cfg_in.variant = pwdata[rlse_pkg::VAR_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         rlse_pkg::REG_RING_SIZE: begin
            prdata = rlse_pkg::DATA_BITS'(cfg_ff.ring_size);
         end
         rlse_pkg::REG_TARGET_SLOT: begin
            prdata = rlse_pkg::DATA_BITS'(cfg_ff.target_slot);
         end
         rlse_pkg::REG_COEF_MODULUS: begin
            prdata = rlse_pkg::DATA_BITS'(cfg_ff.coef_modulus);
         end
         rlse_pkg::REG_VARIANT: begin
            prdata = rlse_pkg::DATA_BITS'(cfg_ff.variant);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ring_size    <= rlse_pkg::RING_MAX_SIZE;
         cfg_ff.target_slot  <= '0;
         cfg_ff.coef_modulus <= rlse_pkg::MOD_BITS'(1) << rlse_pkg::COEF_BITS;
         cfg_ff.variant      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/rlse_store.sv
// Mask coefficient memory with a registered read port and the captured body coefficient.
`default_nettype none

module rlse_store (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            wr_en,
   input  wire logic [rlse_pkg::IDX_BITS-1:0]   wr_addr,
   input  wire logic [rlse_pkg::COEF_BITS-1:0]  wr_data,
   input  wire logic                            body_en,
   input  wire logic [rlse_pkg::COEF_BITS-1:0]  body_data,
   input  wire logic                            rd_en,
   input  wire logic [rlse_pkg::IDX_BITS-1:0]   rd_addr,
   output logic      [rlse_pkg::COEF_BITS-1:0]  rd_data,
   output logic      [rlse_pkg::COEF_BITS-1:0]  body_value
);

   logic [rlse_pkg::COEF_BITS-1:0] mem [rlse_pkg::RING_MAX];
   logic [rlse_pkg::COEF_BITS-1:0] rd_data_ff;
   logic [rlse_pkg::COEF_BITS-1:0] body_ff;
   logic [rlse_pkg::COEF_BITS-1:0] body_in;

   assign rd_data    = rd_data_ff;
   assign body_value = body_ff;
   assign body_in    = body_en ? body_data : body_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         body_ff <= '0;
      end else begin
         body_ff <= body_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/rlse_resp.sv
// Conditional negation modulo q and the response payload register.
`default_nettype none

module rlse_resp (
   input  wire logic                            clock,
   input  wire logic                            load,
   input  wire rlse_pkg::stage_type             stage,
   input  wire logic [rlse_pkg::COEF_BITS-1:0]  rd_data,
   input  wire logic [rlse_pkg::MOD_BITS-1:0]   coef_modulus,
   output rlse_pkg::rsp_type                    rsp
);

   rlse_pkg::rsp_type             rsp_ff;
   rlse_pkg::rsp_type             rsp_in;
   logic [rlse_pkg::MOD_BITS-1:0] diff;

   assign diff = coef_modulus - {1'b0, rd_data};
   assign rsp  = rsp_ff;

   always_comb begin
      rsp_in = rsp_ff;
      if (load) begin
         if (stage.range_error) begin
            rsp_in.mask_value  = '0;
            rsp_in.body_value  = '0;
            rsp_in.range_error = 1'b1;
         end else begin
            if (stage.negate && (rd_data != '0)) begin
               rsp_in.mask_value = diff[rlse_pkg::COEF_BITS-1:0];
            end else begin
               rsp_in.mask_value = rd_data;
            end
            rsp_in.body_value  = stage.body_value;
            rsp_in.range_error = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/rlwe_lwe_sample_extract.sv
// Top level of the LWE sample extraction block: request decode, read stage and response handshake.
//
// Requests arrive on the req_ channel with valid and ready. A write request stores the
// mask element of one coefficient pair and, at the target index, captures the body
// coefficient; it produces no response. A read request for mask index j returns one
// response on the rsp_ channel with the mask coefficient at (target - j) mod n,
// conditionally negated modulo q, the captured body and a range flag.
// Configuration must be written through the APB-style port only while no request is in flight;
// the block does not enforce this. A read response passes the registered memory read and then
// the negation and response register.
// One request is accepted every cycle while req_ready is high; the mask memory takes one write or
// one read per request.
// When the receiver stalls, the response register holds and the read stage fills;
// req_ready then drops until the response is taken.
// Reset restores the configuration defaults and clears the body coefficient. The mask
// memory is not cleared; reading an entry that was never written gives no defined value.
`default_nettype none

module rlwe_lwe_sample_extract (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire rlse_pkg::req_type               req_payload,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output rlse_pkg::rsp_type                    rsp_payload,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [rlse_pkg::ADDR_BITS-1:0]  paddr,
   input  wire logic [rlse_pkg::DATA_BITS-1:0]  pwdata,
   output logic      [rlse_pkg::DATA_BITS-1:0]  prdata,
   output logic                                 pready
);

   rlse_pkg::cfg_type              cfg;
   rlse_pkg::stage_type            stage_ff;
   rlse_pkg::stage_type            stage_in;
   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           out_free;
   logic                           s1_move;
   logic                           accept;
   logic                           rd_accept;
   logic                           wr_en;
   logic                           body_en;
   logic                           body_is_e1;
   logic                           opposite;
   logic [rlse_pkg::SIZE_BITS-1:0] ring_n;
   logic [rlse_pkg::SIZE_BITS-1:0] pos_ext;
   logic [rlse_pkg::SIZE_BITS-1:0] tgt_ext;
   logic [rlse_pkg::SIZE_BITS-1:0] src_ext;
   logic                           pos_in_range;
   logic                           tgt_in_range;
   logic                           pos_le_tgt;
   logic [rlse_pkg::COEF_BITS-1:0] rd_data;
   logic [rlse_pkg::COEF_BITS-1:0] body_value;

   rlse_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign ring_n = (cfg.ring_size > rlse_pkg::RING_MAX_SIZE) ? rlse_pkg::RING_MAX_SIZE
                                                             : cfg.ring_size;
   assign pos_ext      = {1'b0, req_payload.position};
   assign tgt_ext      = {1'b0, cfg.target_slot};
   assign pos_in_range = pos_ext < ring_n;
   assign tgt_in_range = tgt_ext < ring_n;
   assign pos_le_tgt   = pos_ext <= tgt_ext;
   assign src_ext      = pos_le_tgt ? (tgt_ext - pos_ext) : (tgt_ext + ring_n - pos_ext);
   assign body_is_e1   = cfg.variant[0];
   assign opposite     = cfg.variant[1];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;
   assign rd_accept = accept && (req_payload.mode == rlse_pkg::MODE_READ);
   assign wr_en     = accept && (req_payload.mode == rlse_pkg::MODE_WRITE) && pos_in_range;
   assign body_en   = wr_en && (req_payload.position == cfg.target_slot);

   rlse_store u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (req_payload.position),
      .wr_data    (body_is_e1 ? req_payload.elem0_value : req_payload.elem1_value),
      .body_en    (body_en),
      .body_data  (body_is_e1 ? req_payload.elem1_value : req_payload.elem0_value),
      .rd_en      (rd_accept),
      .rd_addr    (src_ext[rlse_pkg::IDX_BITS-1:0]),
      .rd_data    (rd_data),
      .body_value (body_value)
   );

   always_comb begin
      stage_in = stage_ff;
      if (rd_accept) begin
         stage_in.negate      = opposite ? !pos_le_tgt : pos_le_tgt;
         stage_in.range_error = !(tgt_in_range && pos_in_range);
         stage_in.body_value  = body_value;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (rd_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   rlse_resp u_resp (
      .clock        (clock),
      .load         (s1_move),
      .stage        (stage_ff),
      .rd_data      (rd_data),
      .coef_modulus (cfg.coef_modulus),
      .rsp          (rsp_payload)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the LWE sample extraction block.
`default_nettype none

module tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rlse_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rlse_pkg::rsp_type rsp_payload;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [rlse_pkg::ADDR_BITS-1:0] paddr = '0;
   logic [rlse_pkg::DATA_BITS-1:0] pwdata = '0;
   logic [rlse_pkg::DATA_BITS-1:0] prdata;
   logic pready;

   rlwe_lwe_sample_extract dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   localparam logic [rlse_pkg::MOD_BITS-1:0] Q_RESET = rlse_pkg::MOD_BITS'(1) << 60;
   localparam logic [rlse_pkg::MOD_BITS-1:0] Q_MAX   = '1;

   // Shadow of the block's registers and storage.
   logic [rlse_pkg::SIZE_BITS-1:0] cfg_ring = rlse_pkg::RING_MAX_SIZE;
   logic [rlse_pkg::IDX_BITS-1:0]  cfg_target = '0;
   logic [rlse_pkg::MOD_BITS-1:0]  cfg_modulus = Q_RESET;
   logic [rlse_pkg::VAR_BITS-1:0]  cfg_variant = '0;
   logic [rlse_pkg::COEF_BITS-1:0] mask_coef [rlse_pkg::RING_MAX];
   logic [rlse_pkg::COEF_BITS-1:0] body_coef = '0;

   // Entries written so far, so that no request reads an undefined entry.
   bit loaded [rlse_pkg::RING_MAX];

   rlse_pkg::req_type pending [$];
   rlse_pkg::rsp_type samples_due [$];
   rlse_pkg::rsp_type want;
   logic req_took = 1'b0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int response_errors = 0;
   int csr_errors = 0;

   always #5 clock = ~clock;

   function automatic int ring_limit();
      return (cfg_ring > rlse_pkg::RING_MAX_SIZE) ? rlse_pkg::RING_MAX : int'(cfg_ring);
   endfunction

   function automatic logic [rlse_pkg::COEF_BITS-1:0] pick_coef();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return rlse_pkg::COEF_BITS'(cfg_modulus - 1'b1);
         3: return rlse_pkg::COEF_BITS'(cfg_modulus);
         4: return rlse_pkg::COEF_BITS'(1);
         default: return rlse_pkg::COEF_BITS'({$urandom, $urandom});
      endcase
   endfunction

   task automatic extract_lwe(input rlse_pkg::req_type r);
      int n;
      int src;
      logic negate;
      logic [rlse_pkg::COEF_BITS-1:0] v;
      rlse_pkg::rsp_type s;
      n = ring_limit();
      s = '0;
      if (r.mode == rlse_pkg::MODE_WRITE) begin
         if (int'(r.position) < n) begin
            mask_coef[r.position] = cfg_variant[0] ? r.elem0_value : r.elem1_value;
            if (r.position == cfg_target)
               body_coef = cfg_variant[0] ? r.elem1_value : r.elem0_value;
         end
      end else if (int'(cfg_target) >= n || int'(r.position) >= n) begin
         s.range_error = 1'b1;
         samples_due.push_back(s);
      end else begin
         src = (int'(cfg_target) + n - int'(r.position)) % n;
         negate = cfg_variant[1] ? (r.position > cfg_target) : (r.position <= cfg_target);
         v = mask_coef[src];
         if (negate && v != '0)
            v = rlse_pkg::COEF_BITS'(cfg_modulus - rlse_pkg::MOD_BITS'(v));
         s.mask_value = v;
         s.body_value = body_coef;
         samples_due.push_back(s);
      end
   endtask

   task automatic queue_request(input logic mode, input int pos,
                                input logic [rlse_pkg::COEF_BITS-1:0] e0,
                                input logic [rlse_pkg::COEF_BITS-1:0] e1);
      int n;
      int src;
      rlse_pkg::req_type r;
      n = ring_limit();
      if (mode == rlse_pkg::MODE_READ && int'(cfg_target) < n && pos < n) begin
         src = (int'(cfg_target) + n - pos) % n;
         if (!loaded[src]) begin
            mode = rlse_pkg::MODE_WRITE;
            pos = src;
         end
      end
      if (mode == rlse_pkg::MODE_WRITE && pos < n)
         loaded[pos] = 1'b1;
      r.mode = mode;
      r.position = rlse_pkg::IDX_BITS'(pos);
      r.elem0_value = e0;
      r.elem1_value = e1;
      pending.push_back(r);
   endtask

   task automatic wait_idle();
      while (pending.size() != 0 || req_valid || samples_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input rlse_pkg::csr_reg_type idx,
                            input logic [rlse_pkg::DATA_BITS-1:0] value);
      logic [rlse_pkg::DATA_BITS-1:0] readback;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         rlse_pkg::REG_RING_SIZE: begin
            cfg_ring = value[rlse_pkg::SIZE_BITS-1:0];
            readback = rlse_pkg::DATA_BITS'(cfg_ring);
         end
         rlse_pkg::REG_TARGET_SLOT: begin
            cfg_target = value[rlse_pkg::IDX_BITS-1:0];
            readback = rlse_pkg::DATA_BITS'(cfg_target);
         end
         rlse_pkg::REG_COEF_MODULUS: begin
            cfg_modulus = value[rlse_pkg::MOD_BITS-1:0];
            readback = rlse_pkg::DATA_BITS'(cfg_modulus);
         end
         default: begin
            cfg_variant = value[rlse_pkg::VAR_BITS-1:0];
            readback = rlse_pkg::DATA_BITS'(cfg_variant);
         end
      endcase
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== readback) begin
         $error("readback of register %0d: expected %h, got %h", idx, readback, prdata);
         csr_errors++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic start_phase(input int ring, input int target,
                              input logic [rlse_pkg::MOD_BITS-1:0] q,
                              input int var_sel, input int send_pct, input int stall_pct);
      wait_idle();
      write_csr(rlse_pkg::REG_RING_SIZE, rlse_pkg::DATA_BITS'(ring));
      write_csr(rlse_pkg::REG_TARGET_SLOT, rlse_pkg::DATA_BITS'(target));
      write_csr(rlse_pkg::REG_COEF_MODULUS, rlse_pkg::DATA_BITS'(q));
      write_csr(rlse_pkg::REG_VARIANT, rlse_pkg::DATA_BITS'(var_sel));
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Mostly reads and writes around the target within the ring, the rest random noise.
   // Halfway through, the sender holds off until every response is back.
   task automatic random_batch(input int count);
      int n;
      int w;
      int d;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2)
            wait_idle();
         n = ring_limit();
         w = (n > 64) ? 64 : n;
         if (n == 0 || $urandom_range(99) < 12) begin
            queue_request(1'($urandom_range(1)), $urandom_range(4095), pick_coef(),
                          pick_coef());
         end else begin
            d = $urandom_range(w - 1);
            if ($urandom_range(1) == 1)
               queue_request(rlse_pkg::MODE_READ, (n - d) % n, pick_coef(), pick_coef());
            else
               queue_request(rlse_pkg::MODE_WRITE, (int'(cfg_target) + d) % n, pick_coef(),
                             pick_coef());
         end
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (samples_due.size() == 0) begin
               $error("response with no read request outstanding");
               response_errors++;
            end else begin
               want = samples_due.pop_front();
               if (rsp_payload.mask_value !== want.mask_value) begin
                  $error("mask_value: expected %h, got %h", want.mask_value,
                         rsp_payload.mask_value);
                  response_errors++;
               end
               if (rsp_payload.body_value !== want.body_value) begin
                  $error("body_value: expected %h, got %h", want.body_value,
                         rsp_payload.body_value);
                  response_errors++;
               end
               if (rsp_payload.range_error !== want.range_error) begin
                  $error("range_error: expected %h, got %h", want.range_error,
                         rsp_payload.range_error);
                  response_errors++;
               end
            end
         end
         if (req_valid && req_ready)
            extract_lwe(req_payload);
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset configuration: full ring, target zero, modulus two to the sixtieth.
      queue_request(rlse_pkg::MODE_WRITE, 0, '1, '0);
      queue_request(rlse_pkg::MODE_READ, 0, '0, '0);
      queue_request(rlse_pkg::MODE_WRITE, 4095, rlse_pkg::COEF_BITS'(1), '1);
      queue_request(rlse_pkg::MODE_READ, 1, '0, '0);
      queue_request(rlse_pkg::MODE_WRITE, 1, '0, rlse_pkg::COEF_BITS'(1));
      queue_request(rlse_pkg::MODE_READ, 4095, '1, '1);
      queue_request(rlse_pkg::MODE_WRITE, 0, rlse_pkg::COEF_BITS'(7), rlse_pkg::COEF_BITS'(5));
      queue_request(rlse_pkg::MODE_READ, 0, '0, '0);
      random_batch(100);

      // A ring size of zero puts every index out of range.
      start_phase(0, 0, Q_RESET, 0, 0, 0);
      queue_request(rlse_pkg::MODE_READ, 0, '0, '0);
      queue_request(rlse_pkg::MODE_WRITE, 0, '1, '1);
      queue_request(rlse_pkg::MODE_READ, 4095, '1, '1);
      random_batch(40);

      // An oversized ring is limited to the memory depth; the smallest modulus wraps.
      start_phase(8191, 4095, rlse_pkg::MOD_BITS'(2), 1, 0, 0);
      queue_request(rlse_pkg::MODE_WRITE, 4095, '1, rlse_pkg::COEF_BITS'(3));
      queue_request(rlse_pkg::MODE_READ, 0, '0, '0);
      queue_request(rlse_pkg::MODE_READ, 4095, '0, '0);
      random_batch(200);

      // Target beyond the ring and a write beyond the ring.
      start_phase(4, 6, Q_MAX, 2, 79, 0);
      queue_request(rlse_pkg::MODE_WRITE, 4, '1, '1);
      queue_request(rlse_pkg::MODE_WRITE, 2, rlse_pkg::COEF_BITS'(11),
                    rlse_pkg::COEF_BITS'(13));
      queue_request(rlse_pkg::MODE_READ, 0, '0, '0);
      queue_request(rlse_pkg::MODE_READ, 3, '0, '0);
      random_batch(150);

      start_phase(4, 2, Q_MAX, 2, 79, 0);
      for (int k = 0; k < 4; k++)
         queue_request(rlse_pkg::MODE_WRITE, k, pick_coef(), pick_coef());
      queue_request(rlse_pkg::MODE_READ, 0, '0, '0);
      queue_request(rlse_pkg::MODE_READ, 3, '0, '0);
      random_batch(250);

      start_phase(1, 0, Q_RESET, 3, 0, 79);
      queue_request(rlse_pkg::MODE_WRITE, 0, rlse_pkg::COEF_BITS'(9), '1);
      queue_request(rlse_pkg::MODE_READ, 0, '0, '0);
      queue_request(rlse_pkg::MODE_READ, 1, '0, '0);
      random_batch(200);

      start_phase(16, 5, rlse_pkg::MOD_BITS'(rlse_pkg::COEF_BITS'({$urandom, $urandom})),
                  0, 7, 7);
      random_batch(250);

      start_phase(4096, $urandom_range(4095), rlse_pkg::MOD_BITS'({$urandom, $urandom}),
                  $urandom_range(3), 0, 0);
      random_batch(250);

      start_phase($urandom_range(4096, 1), $urandom_range(4095),
                  rlse_pkg::MOD_BITS'({$urandom, $urandom}), $urandom_range(3), 0, 79);
      random_batch(200);

      start_phase($urandom_range(64, 2), $urandom_range(63),
                  rlse_pkg::MOD_BITS'({$urandom, $urandom}), $urandom_range(3), 79, 0);
      random_batch(200);

      wait_idle();
      repeat (6) @(posedge clock);
      if (response_errors == 0 && csr_errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
